// ----- hdl/dust_sensor_poll_controller_assert.svh -----
// Assertion macros for the dust sensor poll controller.
// Included by the top level; depends on nothing else.
`ifndef DUST_SENSOR_POLL_CONTROLLER_ASSERT_SVH
`define DUST_SENSOR_POLL_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define DSPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dspc check failed");

// next-cycle implication
`define DSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dspc check failed");

`endif

// ----- hdl/dspc_pkg.sv -----
// Package for the dust sensor poll controller: codes, widths, frame layout.
// No dependencies.
`default_nettype none
package dspc_pkg;
   localparam int FRAME_BYTES   = 29;
   localparam int IDX_W         = $clog2(FRAME_BYTES);
   localparam int CAPTURE_FIRST = 4;
   localparam int CAPTURE_LAST  = 9;
   localparam int WORDS         = 3;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_STATUS = 2'd1;
   localparam logic [1:0] REQ_BYTE   = 2'd2;

   localparam logic [1:0] CMD_NONE       = 2'd0;
   localparam logic [1:0] CMD_PROBE      = 2'd1;
   localparam logic [1:0] CMD_WRITE_INIT = 2'd2;
   localparam logic [1:0] CMD_READ       = 2'd3;

   localparam logic [1:0] CSR_POLL_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_READ_DELAY    = 2'd1;
   localparam logic [1:0] CSR_INIT_COMMAND  = 2'd2;

   localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;
   localparam logic [7:0]  READ_DELAY_RST    = 8'd40;
   localparam logic [7:0]  INIT_COMMAND_RST  = 8'd136;

   typedef enum logic [5:0] {
      PH_PROBE      = 6'b000001,
      PH_PROBE_BUSY = 6'b000010,
      PH_INIT_BUSY  = 6'b000100,
      PH_DELAY      = 6'b001000,
      PH_READ       = 6'b010000,
      PH_WAIT       = 6'b100000
   } phase_type;
endpackage
`default_nettype wire

// ----- hdl/dspc_req_if.sv -----
// Request channel interface: valid/ready plus tick, status and byte payload.
// Uses dspc_pkg.
`default_nettype none
interface dspc_req_if import dspc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic       bus_ok;
   logic [7:0] rx_byte;

   modport source (output valid, req_type, bus_ok, rx_byte, input ready);
   modport sink   (input valid, req_type, bus_ok, rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/dspc_rsp_if.sv -----
// Response channel interface: valid/ready plus bus command and dust readings.
// Uses dspc_pkg.
`default_nettype none
interface dspc_rsp_if import dspc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  bus_cmd;
   logic [7:0]  cmd_byte;
   logic [15:0] pm1_0;
   logic [15:0] pm2_5;
   logic [15:0] pm10;
   logic        error_flag;
   logic        ready_flag;
   logic        frame_done;
   logic        frame_good;

   modport source (output valid, bus_cmd, cmd_byte, pm1_0, pm2_5, pm10, error_flag,
                   ready_flag, frame_done, frame_good, input ready);
   modport sink   (input valid, bus_cmd, cmd_byte, pm1_0, pm2_5, pm10, error_flag,
                   ready_flag, frame_done, frame_good, output ready);
endinterface
`default_nettype wire

// ----- hdl/dust_sensor_poll_controller.sv -----
// Dust sensor poll controller top level: sequencer, checksum and result register.
// Uses dspc_pkg, dspc_req_if, dspc_rsp_if and the assertion header.
//
//   channel   dir  handshake        content
//   req_chan  in   valid/ready      tick, bus status, frame byte
//   rsp_chan  out  valid/ready      bus command, dust values, flags
//   csr_*     in   write enable     poll interval, read delay, init byte
//
// One transaction per cycle unless rsp_chan stalls; the result is registered and appears
// the cycle after acceptance. A new request is taken whenever the result register is empty
// or being drained in the same cycle. Synchronous reset clears the sequencer,
// counters and dust values; configuration returns to 1000 ms, 40 ms and 0x88.
`default_nettype none
`include "dust_sensor_poll_controller_assert.svh"
module dust_sensor_poll_controller import dspc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   dspc_req_if.sink         req_chan,
   dspc_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic [15:0] poll_interval_ff;
   logic [7:0]  read_delay_ff;
   logic [7:0]  init_command_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] period_count_ff, period_count_in;
   logic [15:0] delay_count_ff, delay_count_in;
   logic        needs_init_ff, needs_init_in;
   logic        error_bit_ff, error_bit_in;
   logic        ready_bit_ff, ready_bit_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [15:0] capture_ff [WORDS];
   logic [15:0] capture_in [WORDS];
   logic [15:0] dust_ff [WORDS];
   logic [15:0] dust_in [WORDS];

   logic        rsp_valid_ff;
   logic [1:0]  bus_cmd_ff, bus_cmd_in;
   logic [7:0]  cmd_byte_ff, cmd_byte_in;
   logic        frame_done_ff, frame_done_in;
   logic        frame_good_ff, frame_good_in;

   logic        accept;
   logic [15:0] period_inc, delay_inc;
   logic        last_byte, in_capture;
   logic [IDX_W-1:0] cap_off;
   logic [1:0]  cap_word;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign period_inc = (period_count_ff == 16'hFFFF) ? period_count_ff : period_count_ff + 16'd1;
   assign delay_inc  = (delay_count_ff == 16'hFFFF) ? delay_count_ff : delay_count_ff + 16'd1;
   assign last_byte  = ({1'b0, byte_index_ff} + (IDX_W+1)'(1)) >= (IDX_W+1)'(FRAME_BYTES);
   assign in_capture = (byte_index_ff >= IDX_W'(CAPTURE_FIRST))
                    && (byte_index_ff <= IDX_W'(CAPTURE_LAST));
   assign cap_off    = byte_index_ff - IDX_W'(CAPTURE_FIRST);
   assign cap_word   = cap_off[2:1];

   always_comb begin
      phase_in        = phase_ff;
      period_count_in = period_count_ff;
      delay_count_in  = delay_count_ff;
      needs_init_in   = needs_init_ff;
      error_bit_in    = error_bit_ff;
      ready_bit_in    = ready_bit_ff;
      byte_index_in   = byte_index_ff;
      running_sum_in  = running_sum_ff;
      capture_in      = capture_ff;
      dust_in         = dust_ff;
      bus_cmd_in      = CMD_NONE;
      cmd_byte_in     = 8'd0;
      frame_done_in   = 1'b0;
      frame_good_in   = 1'b0;

      case (req_chan.req_type)
         REQ_TICK: begin
            if (phase_ff != PH_PROBE) period_count_in = period_inc;
            case (phase_ff)
               PH_PROBE_BUSY, PH_INIT_BUSY, PH_READ: begin
               end
               PH_DELAY: begin
                  delay_count_in = delay_inc;
                  if (delay_inc >= {8'd0, read_delay_ff}) begin
                     bus_cmd_in     = CMD_READ;
                     byte_index_in  = '0;
                     running_sum_in = 8'd0;
                     phase_in       = PH_READ;
                  end
               end
               PH_WAIT: begin
                  delay_count_in = delay_inc;
                  if (delay_inc >= poll_interval_ff) begin
                     bus_cmd_in      = CMD_PROBE;
                     period_count_in = 16'd0;
                     phase_in        = PH_PROBE_BUSY;
                  end
               end
               default: begin
                  bus_cmd_in      = CMD_PROBE;
                  period_count_in = 16'd0;
                  phase_in        = PH_PROBE_BUSY;
               end
            endcase
         end
         REQ_STATUS: begin
            if ((phase_ff == PH_PROBE_BUSY || phase_ff == PH_INIT_BUSY || phase_ff == PH_READ)
                && !req_chan.bus_ok) begin
               error_bit_in   = 1'b1;
               ready_bit_in   = 1'b0;
               needs_init_in  = 1'b0;
               delay_count_in = 16'd0;
               phase_in       = PH_WAIT;
            end else if (phase_ff == PH_PROBE_BUSY) begin
               error_bit_in = 1'b0;
               if (needs_init_ff) begin
                  bus_cmd_in  = CMD_WRITE_INIT;
                  cmd_byte_in = init_command_ff;
                  phase_in    = PH_INIT_BUSY;
               end else begin
                  delay_count_in = 16'd0;
                  phase_in       = PH_DELAY;
               end
            end else if (phase_ff == PH_INIT_BUSY) begin
               needs_init_in  = 1'b0;
               delay_count_in = 16'd0;
               phase_in       = PH_DELAY;
            end
         end
         REQ_BYTE: begin
            if (phase_ff == PH_READ) begin
               if (last_byte) begin
                  frame_done_in = 1'b1;
                  frame_good_in = (running_sum_ff == req_chan.rx_byte);
                  for (int i = 0; i < WORDS; i++)
                     dust_in[i] = frame_good_in ? capture_ff[i] : 16'd0;
                  ready_bit_in   = 1'b1;
                  delay_count_in = period_count_ff;
                  phase_in       = PH_WAIT;
                  byte_index_in  = '0;
               end else begin
                  running_sum_in = running_sum_ff + req_chan.rx_byte;
                  if (in_capture) begin
                     if (!cap_off[0])
                        capture_in[cap_word] = {req_chan.rx_byte, capture_ff[cap_word][7:0]};
                     else
                        capture_in[cap_word] = {capture_ff[cap_word][15:8], req_chan.rx_byte};
                  end
                  byte_index_in = byte_index_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= POLL_INTERVAL_RST;
         read_delay_ff    <= READ_DELAY_RST;
         init_command_ff  <= INIT_COMMAND_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POLL_INTERVAL: poll_interval_ff <= csr_wdata;
            CSR_READ_DELAY:    read_delay_ff    <= csr_wdata[7:0];
            CSR_INIT_COMMAND:  init_command_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PROBE;
         period_count_ff <= 16'd0;
         delay_count_ff  <= 16'd0;
         needs_init_ff   <= 1'b1;
         error_bit_ff    <= 1'b0;
         ready_bit_ff    <= 1'b1;
         byte_index_ff   <= '0;
         running_sum_ff  <= 8'd0;
         for (int i = 0; i < WORDS; i++) begin
            capture_ff[i] <= 16'd0;
            dust_ff[i]    <= 16'd0;
         end
      end else if (accept) begin
         phase_ff        <= phase_in;
         period_count_ff <= period_count_in;
         delay_count_ff  <= delay_count_in;
         needs_init_ff   <= needs_init_in;
         error_bit_ff    <= error_bit_in;
         ready_bit_ff    <= ready_bit_in;
         byte_index_ff   <= byte_index_in;
         running_sum_ff  <= running_sum_in;
         capture_ff      <= capture_in;
         dust_ff         <= dust_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bus_cmd_ff    <= bus_cmd_in;
         cmd_byte_ff   <= cmd_byte_in;
         frame_done_ff <= frame_done_in;
         frame_good_ff <= frame_good_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bus_cmd    = bus_cmd_ff;
   assign rsp_chan.cmd_byte   = cmd_byte_ff;
   assign rsp_chan.pm1_0      = dust_ff[0];
   assign rsp_chan.pm2_5      = dust_ff[1];
   assign rsp_chan.pm10       = dust_ff[2];
   assign rsp_chan.error_flag = error_bit_ff;
   assign rsp_chan.ready_flag = ready_bit_ff;
   assign rsp_chan.frame_done = frame_done_ff;
   assign rsp_chan.frame_good = frame_good_ff;

   `DSPC_ASSERT_SAME(a_good_needs_done, clock, reset, rsp_valid_ff && frame_good_ff, frame_done_ff)
   `DSPC_ASSERT_SAME(a_cmd_byte_only_init, clock, reset,
                     rsp_valid_ff && (bus_cmd_ff != CMD_WRITE_INIT), cmd_byte_ff == 8'd0)
   `DSPC_ASSERT_SAME(a_error_excl_ready, clock, reset, error_bit_ff, !ready_bit_ff)
   `DSPC_ASSERT_NEXT(a_frame_end_waits, clock, reset, accept && frame_done_in,
                     phase_ff == PH_WAIT && byte_index_ff == '0)
endmodule
`default_nettype wire
